/* sv/rgf_pkg.sv */
// Shared types, constants and color wheel function of the rainbow frame generator.
package rgf_pkg;

  parameter int unsigned NumLedsDef = 30;
  parameter logic [15:0] BlendPeriodRst = 16'd100;

  localparam int unsigned ChanN = 3;
  localparam int unsigned IdxW = 6;
  localparam int unsigned PalW = 5;
  localparam int unsigned ProdW = 24;
  localparam int unsigned DivW = 16;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages = ProdW / DivBitsPerStage;

  localparam logic [7:0] WheelSeg1 = 8'd85;
  localparam logic [7:0] WheelSeg2 = 8'd170;
  localparam logic [7:0] LevelMax = 8'd255;

  localparam logic RegBlendPeriod = 1'b0;
  localparam logic OpRainbow = 1'b0;
  localparam logic OpFill = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [7:0]            rot;
    logic [15:0]           phase;
    logic [ChanN-1:0][7:0] fill;
  } rgf_req_t;

  typedef struct packed {
    rgf_req_t        req;
    logic [IdxW-1:0] led_index;
    logic            last;
  } rgf_led_t;

  typedef struct packed {
    logic [ChanN-1:0][7:0] cur;
    logic [ChanN-1:0]      neg;
    logic [IdxW-1:0]       led_index;
    logic                  last;
  } rgf_side_t;

  typedef struct packed {
    logic [ChanN-1:0][DivW-1:0]  rem;
    logic [ChanN-1:0][ProdW-1:0] num;
    rgf_side_t                   side;
  } rgf_div_t;

  function automatic logic [ChanN-1:0][7:0] wheel_rgb(input logic [7:0] v);
    logic [7:0]            u;
    logic [7:0]            up;
    logic [7:0]            dn;
    logic [ChanN-1:0][7:0] rgb;
    if (v < WheelSeg1) begin
      u = v;
    end else if (v < WheelSeg2) begin
      u = v - WheelSeg1;
    end else begin
      u = v - WheelSeg2;
    end
    up = 8'(u * 3);
    dn = LevelMax - up;
    if (v < WheelSeg1) begin
      rgb[0] = dn;
      rgb[1] = 8'd0;
      rgb[2] = up;
    end else if (v < WheelSeg2) begin
      rgb[0] = 8'd0;
      rgb[1] = up;
      rgb[2] = dn;
    end else begin
      rgb[0] = up;
      rgb[1] = dn;
      rgb[2] = 8'd0;
    end
    return rgb;
  endfunction

  function automatic logic [DivW+ProdW-1:0] div_step(input logic [DivW+ProdW-1:0] rn,
                                                      input logic [DivW-1:0] d);
    logic [DivW:0]   t;
    logic            q;
    logic [DivW-1:0] r;
    t = {rn[DivW+ProdW-1:ProdW], rn[ProdW-1]};
    q = (t >= {1'b0, d});
    r = q ? DivW'(t - {1'b0, d}) : t[DivW-1:0];
    return {r, rn[ProdW-2:0], q};
  endfunction

endpackage

/* sv/rgf_seq.sv */
// Request register and LED counter that issues one LED item per cycle while en_i is high.
module rgf_seq #(
  parameter int unsigned NumLeds = rgf_pkg::NumLedsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             req_valid_i,
  input  rgf_pkg::rgf_req_t req_i,
  output logic             req_ready_o,
  output logic             item_valid_o,
  output rgf_pkg::rgf_led_t item_o
);

  localparam logic [rgf_pkg::IdxW-1:0] LastIdx = rgf_pkg::IdxW'(NumLeds - 1);

  logic                       busy_q, busy_d;
  logic [rgf_pkg::IdxW-1:0]   cnt_q, cnt_d;
  rgf_pkg::rgf_req_t          req_q, req_d;
  logic                       is_last;
  logic                       issue;
  logic                       accept;

  assign is_last     = (cnt_q == LastIdx);
  assign issue       = busy_q & en_i;
  assign req_ready_o = ~busy_q | (issue & is_last);
  assign accept      = req_valid_i & req_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    req_d  = req_q;
    if (issue) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      req_d  = req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    req_q <= req_d;
  end

  assign item_valid_o     = busy_q;
  assign item_o.req       = req_q;
  assign item_o.led_index = cnt_q;
  assign item_o.last      = is_last;

endmodule

/* sv/rgf_color.sv */
// Three pipeline stages: palette index, palette lookup with difference, and blend product.
module rgf_color #(
  parameter int unsigned NumLeds = rgf_pkg::NumLedsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              item_valid_i,
  input  rgf_pkg::rgf_led_t item_i,
  output logic              out_valid_o,
  output rgf_pkg::rgf_div_t out_o
);

  localparam int unsigned HalfLeds = NumLeds / 2;
  localparam int unsigned PalDepth = 2 ** rgf_pkg::PalW;
  localparam logic [rgf_pkg::IdxW-1:0] Half6 = rgf_pkg::IdxW'(HalfLeds);
  localparam logic [rgf_pkg::IdxW:0] Full7 = (rgf_pkg::IdxW + 1)'(2 * HalfLeds);
  localparam logic [rgf_pkg::PalW-1:0] PalLast = rgf_pkg::PalW'(HalfLeds - 1);

  logic [rgf_pkg::PalW-1:0]               rot_mod [256];
  logic [rgf_pkg::ChanN-1:0][7:0]         pal [PalDepth];

  for (genvar g = 0; g < 256; g++) begin : g_rot
    localparam logic [rgf_pkg::PalW-1:0] ModVal = rgf_pkg::PalW'(g % HalfLeds);
    assign rot_mod[g] = ModVal;
  end

  for (genvar k = 0; k < PalDepth; k++) begin : g_pal
    if (k < HalfLeds) begin : g_used
      localparam logic [7:0] WheelPos = 8'(255 - (k * 256) / HalfLeds);
      assign pal[k] = rgf_pkg::wheel_rgb(WheelPos);
    end else begin : g_unused
      assign pal[k] = '0;
    end
  end

  logic [rgf_pkg::IdxW-1:0] j;
  logic [rgf_pkg::IdxW-1:0] i6;
  logic [rgf_pkg::IdxW-1:0] sum6;
  logic [rgf_pkg::IdxW-1:0] c6;
  logic [rgf_pkg::PalW-1:0] c_d, n_d;
  logic                     black_d;

  assign j       = item_i.led_index;
  assign black_d = {1'b0, j} >= Full7;
  assign i6      = (j >= Half6) ? (j - Half6) : (Half6 - 1'b1 - j);
  assign sum6    = {1'b0, rot_mod[item_i.req.rot]} + {1'b0, i6[rgf_pkg::PalW-1:0]};
  assign c6      = (sum6 >= Half6) ? (sum6 - Half6) : sum6;
  assign c_d     = c6[rgf_pkg::PalW-1:0];
  assign n_d     = (c_d == PalLast) ? '0 : (c_d + 1'b1);

  logic                     s1_valid_q;
  logic [rgf_pkg::PalW-1:0] s1_c_q, s1_n_q;
  logic                     s1_black_q;
  rgf_pkg::rgf_led_t        s1_item_q;

  logic                                  s2_valid_q;
  logic [rgf_pkg::ChanN-1:0][7:0]        s2_cur_q, s2_cur_d;
  logic [rgf_pkg::ChanN-1:0][8:0]        s2_diff_q, s2_diff_d;
  logic [15:0]                           s2_phase_q;
  logic [rgf_pkg::IdxW-1:0]              s2_idx_q;
  logic                                  s2_last_q;
  logic [rgf_pkg::ChanN-1:0][7:0]        pc, pn;

  assign pc = pal[s1_c_q];
  assign pn = pal[s1_n_q];

  always_comb begin
    for (int ch = 0; ch < rgf_pkg::ChanN; ch++) begin
      if (s1_item_q.req.op == rgf_pkg::OpFill) begin
        s2_cur_d[ch]  = s1_item_q.req.fill[ch];
        s2_diff_d[ch] = '0;
      end else if (s1_black_q) begin
        s2_cur_d[ch]  = '0;
        s2_diff_d[ch] = '0;
      end else begin
        s2_cur_d[ch]  = pc[ch];
        s2_diff_d[ch] = {1'b0, pn[ch]} - {1'b0, pc[ch]};
      end
    end
  end

  logic                                          s3_valid_q;
  rgf_pkg::rgf_div_t                             s3_q, s3_d;
  logic [rgf_pkg::ChanN-1:0][8:0]                abs_diff;

  always_comb begin
    s3_d.rem            = '0;
    s3_d.side.led_index = s2_idx_q;
    s3_d.side.last      = s2_last_q;
    for (int ch = 0; ch < rgf_pkg::ChanN; ch++) begin
      s3_d.side.neg[ch] = s2_diff_q[ch][8];
      s3_d.side.cur[ch] = s2_cur_q[ch];
      abs_diff[ch]      = s2_diff_q[ch][8] ? (9'd0 - s2_diff_q[ch]) : s2_diff_q[ch];
      s3_d.num[ch]      = rgf_pkg::ProdW'(abs_diff[ch][7:0]) * rgf_pkg::ProdW'(s2_phase_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= item_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_c_q     <= c_d;
      s1_n_q     <= n_d;
      s1_black_q <= black_d;
      s1_item_q  <= item_i;
      s2_cur_q   <= s2_cur_d;
      s2_diff_q  <= s2_diff_d;
      s2_phase_q <= s1_item_q.req.phase;
      s2_idx_q   <= s1_item_q.led_index;
      s2_last_q  <= s1_item_q.last;
      s3_q       <= s3_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_o       = s3_q;

endmodule

/* sv/rgf_div.sv */
// Pipelined restoring divider, two quotient bits per stage, for the three color channels.
module rgf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [rgf_pkg::DivW-1:0]   divisor_i,
  input  logic                       in_valid_i,
  input  rgf_pkg::rgf_div_t          in_i,
  output logic                       out_valid_o,
  output rgf_pkg::rgf_div_t          out_o
);

  logic              valid_q [rgf_pkg::DivStages];
  rgf_pkg::rgf_div_t stage_q [rgf_pkg::DivStages];

  for (genvar s = 0; s < rgf_pkg::DivStages; s++) begin : g_stage
    logic              prev_valid;
    rgf_pkg::rgf_div_t prev;
    rgf_pkg::rgf_div_t nxt;

    if (s == 0) begin : g_first
      assign prev_valid = in_valid_i;
      assign prev       = in_i;
    end else begin : g_rest
      assign prev_valid = valid_q[s-1];
      assign prev       = stage_q[s-1];
    end

    always_comb begin
      logic [rgf_pkg::DivW+rgf_pkg::ProdW-1:0] rn;
      nxt = prev;
      for (int ch = 0; ch < rgf_pkg::ChanN; ch++) begin
        rn = {prev.rem[ch], prev.num[ch]};
        for (int b = 0; b < rgf_pkg::DivBitsPerStage; b++) begin
          rn = rgf_pkg::div_step(rn, divisor_i);
        end
        nxt.rem[ch] = rn[rgf_pkg::DivW+rgf_pkg::ProdW-1:rgf_pkg::ProdW];
        nxt.num[ch] = rn[rgf_pkg::ProdW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[s] <= nxt;
      end
    end
  end

  assign out_valid_o = valid_q[rgf_pkg::DivStages-1];
  assign out_o       = stage_q[rgf_pkg::DivStages-1];

endmodule

/* sv/rainbow_gradient_frame_generator_top.sv */
// Top level of the rainbow gradient frame generator with its register port and output stage.
// One request yields NumLeds colors, one per cycle unless m_axis_tready stalls the output.
// A new request is taken while idle or as the last LED of the previous frame is issued.
// The pipeline holds 3 color stages, the 12-stage divider and the output register.
// Reset clears all valid bits and the busy flag and sets the blend period to 100.
module rainbow_gradient_frame_generator_top #(
  parameter int unsigned NumLeds = rgf_pkg::NumLedsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // rotation, phase, fill_red, fill_green, fill_blue
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // led_index, red, green, blue, zero padding
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                       en;
  logic [rgf_pkg::DivW-1:0]   blend_period_q;
  rgf_pkg::rgf_req_t          req;
  logic                       item_valid;
  rgf_pkg::rgf_led_t          item;
  logic                       col_valid;
  rgf_pkg::rgf_div_t          col;
  logic                       div_valid;
  rgf_pkg::rgf_div_t          quo;

  logic                           out_valid_q;
  logic [rgf_pkg::IdxW-1:0]       out_idx_q;
  logic [rgf_pkg::ChanN-1:0][7:0] out_rgb_q, out_rgb_d;
  logic                           out_last_q;

  assign en     = m_axis_tready | ~out_valid_q;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_period_q <= rgf_pkg::BlendPeriodRst;
    end else if (psel && penable && pwrite && (paddr[2] == rgf_pkg::RegBlendPeriod)) begin
      blend_period_q <= pwdata[rgf_pkg::DivW-1:0];
    end
  end

  assign prdata = (paddr[2] == rgf_pkg::RegBlendPeriod) ? {16'd0, blend_period_q} : 32'd0;

  assign req.op    = s_axis_tuser;
  assign req.rot   = s_axis_tdata[7:0];
  assign req.phase = s_axis_tdata[23:8];
  assign req.fill  = {s_axis_tdata[47:40], s_axis_tdata[39:32], s_axis_tdata[31:24]};

  rgf_seq #(
    .NumLeds(NumLeds)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  rgf_color #(
    .NumLeds(NumLeds)
  ) u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .item_valid_i(item_valid),
    .item_i      (item),
    .out_valid_o (col_valid),
    .out_o       (col)
  );

  rgf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .divisor_i  (blend_period_q),
    .in_valid_i (col_valid),
    .in_i       (col),
    .out_valid_o(div_valid),
    .out_o      (quo)
  );

  always_comb begin
    for (int ch = 0; ch < rgf_pkg::ChanN; ch++) begin
      if (blend_period_q == '0) begin
        out_rgb_d[ch] = quo.side.cur[ch];
      end else if (quo.side.neg[ch]) begin
        out_rgb_d[ch] = quo.side.cur[ch] - quo.num[ch][7:0];
      end else begin
        out_rgb_d[ch] = quo.side.cur[ch] + quo.num[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_idx_q  <= quo.side.led_index;
      out_rgb_q  <= out_rgb_d;
      out_last_q <= quo.side.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_rgb_q[2], out_rgb_q[1], out_rgb_q[0], out_idx_q};

endmodule
